>>> sv/jsv_pkg.sv
// jsv_pkg: shared types and constants for the json stream validator
// no dependencies
package jsv_pkg;

  localparam int MaxDepth = 64;
  localparam int DepthW   = $clog2(MaxDepth + 1);
  localparam int PtrW     = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_VALID    = 3'd1,
    ST_BADCHAR  = 3'd2,
    ST_BADTOKEN = 3'd3,
    ST_BADEND   = 3'd4,
    ST_EMPTYKEY = 3'd5,
    ST_DEPTH    = 3'd6
  } status_e;

endpackage

>>> sv/json_stream_validator.sv
// json_stream_validator: top level, byte-wise json syntax checker
// depends on jsv_pkg
//
// usage
//  - input channel: func_i/text_byte_i with in_valid_i, in_stall_o
//    func_i = 0 carries one text byte, func_i = 1 marks end of text
//  - output channel: status_o/done_res_o/nest_depth_o with out_valid_o,
//    out_stall_i; exactly one result transfer per input transfer
//  - one byte per cycle while in_stall_o is low: all lexer, number/word matcher
//    and grammar updates are computed combinationally from the current state
//  - each result is registered, in the result register or in the skid register
//  - the nesting stack is a 1-bit-per-level array indexed by open count;
//    the innermost kind sits in a register, a close reloads it from the
//    entry below with a clocked read
//  - receiver stall: the result register holds; a skid register takes
//    one more result so the input stalls only once the skid is full
//  - reset: lexer idle, expecting a value, no error, no open levels;
//    the end marker returns the verdict and clears the same state
//  - errors stick until the end marker; status 6 flags depth overflow
module json_stream_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic       done_res_o,
  output logic [6:0] nest_depth_o
);

  localparam int DW = jsv_pkg::DepthW;
  localparam int PW = jsv_pkg::PtrW;

  typedef enum logic [2:0] {
    LX_IDLE, LX_STRING, LX_ESC, LX_ESCHEX, LX_NUMBER, LX_WORD
  } lex_e;
  typedef enum logic [2:0] {
    G_VALUE, G_KEY, G_KVSEP, G_VALSEP, G_END
  } gram_e;
  typedef enum logic [3:0] {
    TK_NONE, TK_STR, TK_SCALAR, TK_LBRACE, TK_RBRACE, TK_LBRACK,
    TK_RBRACK, TK_COLON, TK_COMMA, TK_BAD
  } tok_e;
  typedef enum logic [2:0] {
    N_START, N_INT, N_DOTNODIG, N_FRAC, N_EXP, N_EXPSIGN, N_EXPDIG, N_BAD
  } num_e;

  localparam logic LvObj = 1'b0;
  localparam logic LvArr = 1'b1;
  localparam logic [3:0] WBad = 4'd14;

  // state
  lex_e            lex_q, lex_d;
  logic [1:0]      hex_q, hex_d;
  gram_e           gram_q;
  logic [DW-1:0]   open_q;
  logic            stack_q [jsv_pkg::MaxDepth];
  num_e            num_q, num_d;
  logic [3:0]      word_q, word_d;
  logic            empty_q, empty_d;
  logic [2:0]      err_q;

  // output register plus skid
  logic       ov_q, sv_q;
  logic [2:0] ost_q, sst_q;
  logic       odn_q, sdn_q;
  logic [6:0] odp_q, sdp_q;

  logic accept, out_take;
  assign in_stall_o  = sv_q;
  assign accept      = in_valid_i & ~sv_q;
  assign out_take    = ov_q & ~out_stall_i;
  assign out_valid_o = ov_q;
  assign status_o    = ost_q;
  assign done_res_o  = odn_q;
  assign nest_depth_o = odp_q;

  logic [7:0] c;
  assign c = text_byte_i;

  logic is_dig, is_alpha, is_hex, is_sp, is_exp, is_numch;
  always_comb begin
    is_dig   = (c >= 8'h30) && (c <= 8'h39);
    is_alpha = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    is_hex   = is_dig || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    is_sp    = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
    is_exp   = (c == 8'h65) || (c == 8'h45);
    is_numch = is_dig || is_exp || (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2e);
  end

  function automatic num_e num_next(num_e s, logic d, logic e, logic [7:0] ch);
    num_e r;
    r = N_BAD;
    case (s)
      N_START:    r = d ? N_INT : ((ch == 8'h2e) ? N_DOTNODIG : N_BAD);
      N_INT:      r = d ? N_INT : ((ch == 8'h2e) ? N_FRAC : (e ? N_EXP : N_BAD));
      N_DOTNODIG: r = d ? N_FRAC : N_BAD;
      N_FRAC:     r = d ? N_FRAC : (e ? N_EXP : N_BAD);
      N_EXP:      r = d ? N_EXPDIG :
                      (((ch == 8'h2b) || (ch == 8'h2d)) ? N_EXPSIGN : N_BAD);
      N_EXPSIGN:  r = d ? N_EXPDIG : N_BAD;
      N_EXPDIG:   r = d ? N_EXPDIG : N_BAD;
      default:    r = N_BAD;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] word_next(logic [3:0] s, logic [7:0] ch);
    logic [7:0] ex;
    logic [3:0] r;
    ex = 8'h00;
    case (s)
      4'd1: ex = 8'h72; 4'd2: ex = 8'h75; 4'd3: ex = 8'h65;
      4'd5: ex = 8'h61; 4'd6: ex = 8'h6c; 4'd7: ex = 8'h73; 4'd8: ex = 8'h65;
      4'd10: ex = 8'h75; 4'd11: ex = 8'h6c; 4'd12: ex = 8'h6c;
      default: ex = 8'h00;
    endcase
    if (s == 4'd0) begin
      r = (ch == 8'h74) ? 4'd1 : (ch == 8'h66) ? 4'd5 : (ch == 8'h6e) ? 4'd10 : WBad;
    end else if (ex != 8'h00 && ch == ex) begin
      r = s + 4'd1;
    end else begin
      r = WBad;
    end
    return r;
  endfunction

  // token classification: a pending number/word may flush, then the byte
  // itself may form a second token
  tok_e  flush_tk, byte_tk;
  logic  str_empty_tk;
  logic  lex_bad;        // bad character from lexer
  logic  byte_starts;    // byte processed in idle context
  always_comb begin
    lex_d   = lex_q;
    hex_d   = hex_q;
    num_d   = num_q;
    word_d  = word_q;
    empty_d = empty_q;
    flush_tk = TK_NONE;
    byte_tk  = TK_NONE;
    str_empty_tk = 1'b0;
    lex_bad  = 1'b0;
    byte_starts = 1'b0;
    if (func_i) begin
      case (lex_q)
        LX_NUMBER: flush_tk = ((num_q == N_INT) || (num_q == N_FRAC) ||
                               (num_q == N_EXPDIG)) ? TK_SCALAR : TK_BAD;
        LX_WORD:   flush_tk = ((word_q == 4'd4) || (word_q == 4'd9) ||
                               (word_q == 4'd13)) ? TK_SCALAR : TK_BAD;
        LX_STRING, LX_ESC, LX_ESCHEX: flush_tk = TK_BAD;
        default:   flush_tk = TK_NONE;
      endcase
    end else begin
      case (lex_q)
        LX_STRING: begin
          if (c == 8'h22) begin
            lex_d = LX_IDLE;
            byte_tk = TK_STR;
            str_empty_tk = empty_q;
          end else begin
            empty_d = 1'b0;
            if (c == 8'h5c) lex_d = LX_ESC;
          end
        end
        LX_ESC: begin
          if (c == 8'h22 || c == 8'h5c || c == 8'h2f || c == 8'h62 ||
              c == 8'h66 || c == 8'h6e || c == 8'h72 || c == 8'h74) begin
            lex_d = LX_STRING;
          end else if (c == 8'h75) begin
            lex_d = LX_ESCHEX;
            hex_d = 2'd0;
          end else begin
            lex_bad = 1'b1;
          end
        end
        LX_ESCHEX: begin
          if (!is_hex) begin
            lex_bad = 1'b1;
          end else if (hex_q == 2'd3) begin
            hex_d = 2'd0;
            lex_d = LX_STRING;
          end else begin
            hex_d = hex_q + 2'd1;
          end
        end
        LX_NUMBER: begin
          if (is_numch) begin
            num_d = num_next(num_q, is_dig, is_exp, c);
          end else begin
            flush_tk = ((num_q == N_INT) || (num_q == N_FRAC) ||
                        (num_q == N_EXPDIG)) ? TK_SCALAR : TK_BAD;
            lex_d = LX_IDLE;
            byte_starts = 1'b1;
          end
        end
        LX_WORD: begin
          if (is_alpha) begin
            word_d = word_next(word_q, c);
          end else begin
            flush_tk = ((word_q == 4'd4) || (word_q == 4'd9) ||
                        (word_q == 4'd13)) ? TK_SCALAR : TK_BAD;
            lex_d = LX_IDLE;
            byte_starts = 1'b1;
          end
        end
        default: byte_starts = 1'b1;
      endcase
      if (byte_starts) begin
        if (is_sp) begin
          byte_tk = TK_NONE;
        end else if (c == 8'h7b) byte_tk = TK_LBRACE;
        else if (c == 8'h7d) byte_tk = TK_RBRACE;
        else if (c == 8'h5b) byte_tk = TK_LBRACK;
        else if (c == 8'h5d) byte_tk = TK_RBRACK;
        else if (c == 8'h3a) byte_tk = TK_COLON;
        else if (c == 8'h2c) byte_tk = TK_COMMA;
        else if (c == 8'h22) begin
          lex_d = LX_STRING;
          empty_d = 1'b1;
        end else if (c == 8'h2d || is_dig) begin
          lex_d = LX_NUMBER;
          num_d = (c == 8'h2d) ? N_START : N_INT;
        end else if (is_alpha) begin
          lex_d = LX_WORD;
          word_d = word_next(4'd0, c);
        end else begin
          lex_bad = 1'b1;
        end
      end
    end
  end

  // grammar step, applied to up to two tokens in sequence
  typedef struct packed {
    gram_e         gs;
    logic [DW-1:0] oc;
    logic [2:0]    st;
    logic          push;
    logic          kind;
  } gstep_t;

  function automatic gstep_t gram_step(gram_e gs, logic [DW-1:0] oc, logic top,
                                       tok_e tk, logic emp);
    gstep_t r;
    logic   has;
    has = (oc != '0);
    r.gs = gs; r.oc = oc; r.st = jsv_pkg::ST_OK; r.push = 1'b0; r.kind = LvObj;
    if (tk != TK_NONE) begin
      case (gs)
        G_VALUE: begin
          if (tk == TK_STR || tk == TK_SCALAR) begin
            r.gs = has ? G_VALSEP : G_END;
          end else if (tk == TK_LBRACE || tk == TK_LBRACK) begin
            if (tk == TK_LBRACE) r.gs = G_KEY;
            if (oc >= DW'(jsv_pkg::MaxDepth)) begin
              r.st = jsv_pkg::ST_DEPTH;
            end else begin
              r.push = 1'b1;
              r.kind = (tk == TK_LBRACK) ? LvArr : LvObj;
              r.oc = oc + 1'b1;
            end
          end else if (tk == TK_RBRACK && has && top == LvArr) begin
            r.oc = oc - 1'b1;
            r.gs = (oc != DW'(1)) ? G_VALSEP : G_END;
          end else begin
            r.st = jsv_pkg::ST_BADTOKEN;
          end
        end
        G_KEY: begin
          if (tk == TK_STR) begin
            if (emp) r.st = jsv_pkg::ST_EMPTYKEY;
            else r.gs = G_KVSEP;
          end else if (tk == TK_RBRACE && has && top == LvObj) begin
            r.oc = oc - 1'b1;
            r.gs = G_VALSEP;
          end else begin
            r.st = jsv_pkg::ST_BADTOKEN;
          end
        end
        G_KVSEP: begin
          if (tk == TK_COLON) r.gs = G_VALUE;
          else r.st = jsv_pkg::ST_BADTOKEN;
        end
        G_VALSEP: begin
          if (has && tk == TK_COMMA) begin
            r.gs = (top == LvArr) ? G_VALUE : G_KEY;
          end else if (has && ((tk == TK_RBRACE && top == LvObj) ||
                               (tk == TK_RBRACK && top == LvArr))) begin
            r.oc = oc - 1'b1;
          end else begin
            r.st = jsv_pkg::ST_BADTOKEN;
          end
        end
        default: r.st = jsv_pkg::ST_BADEND;
      endcase
    end
    return r;
  endfunction

  logic          top_q;    // kind of the innermost open level
  logic          top1;
  gstep_t        g1, g2;
  always_comb begin
    g1 = gram_step(gram_q, open_q, top_q, flush_tk, 1'b0);
    // a flushed scalar never changes the depth, so the top is unchanged
    top1 = top_q;
    g2 = gram_step(g1.gs, g1.oc, top1, byte_tk, str_empty_tk);
  end

  // combine into a step status
  logic [2:0]    step_st, final_st;
  gram_e         gram_d;
  logic [DW-1:0] open_d;
  always_comb begin
    step_st = jsv_pkg::ST_OK;
    gram_d = gram_q;
    open_d = open_q;
    if (g1.st != jsv_pkg::ST_OK) begin
      step_st = g1.st;
      gram_d = g1.gs;
      open_d = g1.oc;
    end else if (lex_bad && flush_tk == TK_NONE && byte_tk == TK_NONE &&
                 !byte_starts) begin
      step_st = jsv_pkg::ST_BADCHAR;
    end else begin
      gram_d = g2.gs;
      open_d = g2.oc;
      step_st = lex_bad ? jsv_pkg::ST_BADCHAR : g2.st;
    end
    // the verdict looks at the grammar after the pending token is flushed
    final_st = jsv_pkg::ST_OK;
    if (err_q != jsv_pkg::ST_OK) final_st = err_q;
    else if (g1.st != jsv_pkg::ST_OK) final_st = g1.st;
    else if (g1.oc != '0 || g1.gs == G_VALUE) final_st = jsv_pkg::ST_BADEND;
    else final_st = jsv_pkg::ST_VALID;
  end

  logic do_push, do_pop;
  logic [PW-1:0] push_idx, pop_idx;
  logic [DW-1:0] om2;
  logic push_kind;
  assign do_push   = accept && !func_i && (err_q == jsv_pkg::ST_OK) && !lex_bad &&
                     (g1.st == jsv_pkg::ST_OK) && g2.push;
  assign do_pop    = accept && !func_i && (err_q == jsv_pkg::ST_OK) && (open_d < open_q);
  assign push_idx  = g1.oc[PW-1:0];
  assign push_kind = g2.kind;
  // entry below the current top becomes the new top on a close
  assign om2       = open_q - DW'(2);
  assign pop_idx   = om2[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      stack_q[push_idx] <= push_kind;
      top_q <= push_kind;
    end else if (do_pop) begin
      top_q <= stack_q[pop_idx];
    end
  end

  logic [2:0] res_st;
  logic [6:0] res_dp;
  assign res_st = func_i ? final_st :
                  ((err_q != jsv_pkg::ST_OK) ? err_q : step_st);
  // a text byte reports the depth after its own step
  assign res_dp = (func_i || (err_q != jsv_pkg::ST_OK)) ? 7'(open_q) : 7'(open_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_q   <= LX_IDLE;
      hex_q   <= 2'd0;
      gram_q  <= G_VALUE;
      open_q  <= '0;
      num_q   <= N_START;
      word_q  <= 4'd0;
      empty_q <= 1'b1;
      err_q   <= jsv_pkg::ST_OK;
    end else if (accept) begin
      if (func_i) begin
        lex_q   <= LX_IDLE;
        hex_q   <= 2'd0;
        gram_q  <= G_VALUE;
        open_q  <= '0;
        num_q   <= N_START;
        word_q  <= 4'd0;
        empty_q <= 1'b1;
        err_q   <= jsv_pkg::ST_OK;
      end else if (err_q == jsv_pkg::ST_OK) begin
        lex_q   <= lex_d;
        hex_q   <= hex_d;
        num_q   <= num_d;
        word_q  <= word_d;
        empty_q <= empty_d;
        gram_q  <= gram_d;
        open_q  <= open_d;
        err_q   <= step_st;
      end
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (!ov_q || out_take) begin
        if (sv_q) begin
          ov_q <= 1'b1;
          sv_q <= 1'b0;
        end else begin
          ov_q <= accept;
        end
      end else if (accept) begin
        sv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || out_take) begin
      if (sv_q) begin
        ost_q <= sst_q; odn_q <= sdn_q; odp_q <= sdp_q;
      end else begin
        ost_q <= res_st; odn_q <= func_i; odp_q <= res_dp;
      end
    end else if (accept) begin
      sst_q <= res_st; sdn_q <= func_i; sdp_q <= res_dp;
    end
  end

  // checks
  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= DW'(jsv_pkg::MaxDepth))
    else $error("open count beyond stack depth");
  a_err_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != jsv_pkg::ST_OK && !(accept && func_i)) |=> $stable(err_q))
    else $error("error code changed before end marker");
  a_skid_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid holds data while output empty");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i) |=> (open_q == '0 && err_q == jsv_pkg::ST_OK))
    else $error("end marker did not clear state");

endmodule

>>> bench/tb_json_stream_validator.sv
// self-checking bench for json_stream_validator: directed and random json text
// depends on jsv_pkg and the json_stream_validator rtl
`timescale 1ns / 100ps

module tb_json_stream_validator;

  // lexer modes of the predictor
  typedef enum logic [2:0] {
    LX_IDLE, LX_STRING, LX_ESC, LX_ESCHEX, LX_NUMBER, LX_WORD
  } lex_e;
  // grammar expectations
  typedef enum logic [2:0] {
    G_VALUE, G_KEY, G_KVSEP, G_VALSEP, G_END
  } gram_e;
  // token classes fed into the grammar
  typedef enum logic [3:0] {
    TK_STR, TK_SCALAR, TK_LBRACE, TK_RBRACE, TK_LBRACK, TK_RBRACK,
    TK_COLON, TK_COMMA, TK_BAD
  } tok_e;
  // number shapes
  typedef enum logic [2:0] {
    N_START, N_INT, N_DOTNODIG, N_FRAC, N_EXP, N_EXPSIGN, N_EXPDIG, N_BAD
  } num_e;

  localparam logic LV_OBJ = 1'b0;
  localparam logic LV_ARR = 1'b1;
  localparam logic F_TEXT = 1'b0;
  localparam logic F_END  = 1'b1;
  localparam logic [3:0] W_BAD = 4'd14;

  typedef struct packed {
    logic       func;
    logic [7:0] text_byte;
  } byte_item_t;

  typedef struct packed {
    jsv_pkg::status_e status;
    logic             done_res;
    logic [6:0]       nest_depth;
  } verdict_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       func_i = 1'b0;
  logic [7:0] text_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic       done_res_o;
  logic [6:0] nest_depth_o;

  json_stream_validator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .text_byte_i,
    .out_valid_o, .out_stall_i, .status_o, .done_res_o, .nest_depth_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  lex_e             lex_mode;
  logic [1:0]       hex_count;
  gram_e            gram;
  int               depth;
  logic             kind_stack [jsv_pkg::MaxDepth];
  num_e             num_shape;
  logic [3:0]       word_pos;
  logic             str_empty;
  jsv_pkg::status_e sticky_err;

  byte_item_t pending_bytes[$];
  verdict_t   expected_verdicts[$];
  int         fail_count = 0;
  int         phase = 0;          // idling profile
  bit         stim_done = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_exp(logic [7:0] c);
    return c == "e" || c == "E";
  endfunction

  function automatic num_e number_advance(num_e s, logic [7:0] c);
    bit d;
    d = is_digit(c);
    case (s)
      N_START:    return d ? N_INT : (c == "." ? N_DOTNODIG : N_BAD);
      N_INT:      return d ? N_INT : (c == "." ? N_FRAC : (is_exp(c) ? N_EXP : N_BAD));
      N_DOTNODIG: return d ? N_FRAC : N_BAD;
      N_FRAC:     return d ? N_FRAC : (is_exp(c) ? N_EXP : N_BAD);
      N_EXP:      return d ? N_EXPDIG : ((c == "+" || c == "-") ? N_EXPSIGN : N_BAD);
      N_EXPSIGN:  return d ? N_EXPDIG : N_BAD;
      N_EXPDIG:   return d ? N_EXPDIG : N_BAD;
      default:    return N_BAD;
    endcase
  endfunction

  // word positions: true 1..4, false 5..9, null 10..13
  function automatic logic [3:0] word_advance(logic [3:0] s, logic [7:0] c);
    logic [7:0] want;
    if (s == 4'd0) begin
      return c == "t" ? 4'd1 : (c == "f" ? 4'd5 : (c == "n" ? 4'd10 : W_BAD));
    end
    case (s)
      4'd1: want = "r";  4'd2: want = "u";  4'd3: want = "e";
      4'd5: want = "a";  4'd6: want = "l";  4'd7: want = "s";  4'd8: want = "e";
      4'd10: want = "u"; 4'd11: want = "l"; 4'd12: want = "l";
      default: want = 8'h00;
    endcase
    if (want != 8'h00 && c == want) return s + 4'd1;
    return W_BAD;
  endfunction

  function automatic logic top_kind();
    return kind_stack[(depth - 1) % jsv_pkg::MaxDepth];
  endfunction

  function automatic jsv_pkg::status_e open_level(logic kind);
    if (depth >= jsv_pkg::MaxDepth) return jsv_pkg::ST_DEPTH;
    kind_stack[depth] = kind;
    depth++;
    return jsv_pkg::ST_OK;
  endfunction

  function automatic jsv_pkg::status_e apply_grammar(tok_e tk, logic empty);
    case (gram)
      G_VALUE: begin
        if (tk == TK_STR || tk == TK_SCALAR) begin
          gram = depth != 0 ? G_VALSEP : G_END;
          return jsv_pkg::ST_OK;
        end
        if (tk == TK_LBRACE) begin
          gram = G_KEY;
          return open_level(LV_OBJ);
        end
        if (tk == TK_LBRACK) return open_level(LV_ARR);
        // lenient: "[1,]" and "[]"
        if (tk == TK_RBRACK && depth != 0 && top_kind() == LV_ARR) begin
          depth--;
          gram = depth != 0 ? G_VALSEP : G_END;
          return jsv_pkg::ST_OK;
        end
        return jsv_pkg::ST_BADTOKEN;
      end
      G_KEY: begin
        if (tk == TK_STR) begin
          if (empty) return jsv_pkg::ST_EMPTYKEY;
          gram = G_KVSEP;
          return jsv_pkg::ST_OK;
        end
        // closing an object leaves valsep even at top level
        if (tk == TK_RBRACE && depth != 0 && top_kind() == LV_OBJ) begin
          depth--;
          gram = G_VALSEP;
          return jsv_pkg::ST_OK;
        end
        return jsv_pkg::ST_BADTOKEN;
      end
      G_KVSEP: begin
        if (tk == TK_COLON) begin
          gram = G_VALUE;
          return jsv_pkg::ST_OK;
        end
        return jsv_pkg::ST_BADTOKEN;
      end
      G_VALSEP: begin
        if (depth != 0) begin
          if (tk == TK_COMMA) begin
            gram = top_kind() == LV_ARR ? G_VALUE : G_KEY;
            return jsv_pkg::ST_OK;
          end
          if ((tk == TK_RBRACE && top_kind() == LV_OBJ) ||
              (tk == TK_RBRACK && top_kind() == LV_ARR)) begin
            depth--;
            return jsv_pkg::ST_OK;
          end
        end
        return jsv_pkg::ST_BADTOKEN;
      end
      default: return jsv_pkg::ST_BADEND;
    endcase
  endfunction

  function automatic jsv_pkg::status_e finish_token();
    tok_e tk;
    case (lex_mode)
      LX_NUMBER: tk = (num_shape inside {N_INT, N_FRAC, N_EXPDIG}) ? TK_SCALAR : TK_BAD;
      LX_WORD:   tk = (word_pos inside {4'd4, 4'd9, 4'd13}) ? TK_SCALAR : TK_BAD;
      LX_STRING, LX_ESC, LX_ESCHEX: tk = TK_BAD;
      default: return jsv_pkg::ST_OK;
    endcase
    lex_mode = LX_IDLE;
    return apply_grammar(tk, 1'b0);
  endfunction

  function automatic jsv_pkg::status_e start_token(logic [7:0] c);
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return jsv_pkg::ST_OK;
    case (c)
      "{": return apply_grammar(TK_LBRACE, 1'b0);
      "}": return apply_grammar(TK_RBRACE, 1'b0);
      "[": return apply_grammar(TK_LBRACK, 1'b0);
      "]": return apply_grammar(TK_RBRACK, 1'b0);
      ":": return apply_grammar(TK_COLON, 1'b0);
      ",": return apply_grammar(TK_COMMA, 1'b0);
      "\"": begin
        lex_mode = LX_STRING;
        str_empty = 1'b1;
        return jsv_pkg::ST_OK;
      end
      default: ;
    endcase
    if (c == "-" || is_digit(c)) begin
      lex_mode = LX_NUMBER;
      num_shape = c == "-" ? N_START : N_INT;
      return jsv_pkg::ST_OK;
    end
    if (is_alpha(c)) begin
      lex_mode = LX_WORD;
      word_pos = word_advance(4'd0, c);
      return jsv_pkg::ST_OK;
    end
    return jsv_pkg::ST_BADCHAR;
  endfunction

  function automatic jsv_pkg::status_e lex_byte(logic [7:0] c);
    jsv_pkg::status_e err;
    err = jsv_pkg::ST_OK;
    case (lex_mode)
      LX_STRING: begin
        if (c == "\"") begin
          lex_mode = LX_IDLE;
          err = apply_grammar(TK_STR, str_empty);
        end else begin
          str_empty = 1'b0;
          if (c == "\\") lex_mode = LX_ESC;
        end
      end
      LX_ESC: begin
        if (c inside {"\"", "\\", "/", "b", "f", "n", "r", "t"}) lex_mode = LX_STRING;
        else if (c == "u") begin
          lex_mode = LX_ESCHEX;
          hex_count = 2'd0;
        end else err = jsv_pkg::ST_BADCHAR;
      end
      LX_ESCHEX: begin
        if (!is_hex(c)) err = jsv_pkg::ST_BADCHAR;
        else if (hex_count == 2'd3) begin
          hex_count = 2'd0;
          lex_mode = LX_STRING;
        end else hex_count++;
      end
      LX_NUMBER: begin
        if (is_digit(c) || c inside {"+", "-", ".", "e", "E"}) begin
          num_shape = number_advance(num_shape, c);
        end else begin
          // token ends here, same byte then starts the next one
          err = finish_token();
          if (err == jsv_pkg::ST_OK) err = start_token(c);
        end
      end
      LX_WORD: begin
        if (is_alpha(c)) word_pos = word_advance(word_pos, c);
        else begin
          err = finish_token();
          if (err == jsv_pkg::ST_OK) err = start_token(c);
        end
      end
      default: err = start_token(c);
    endcase
    return err;
  endfunction

  function automatic void clear_predictor();
    lex_mode = LX_IDLE;
    hex_count = 2'd0;
    gram = G_VALUE;
    depth = 0;
    for (int i = 0; i < jsv_pkg::MaxDepth; i++) kind_stack[i] = LV_OBJ;
    num_shape = N_START;
    word_pos = 4'd0;
    str_empty = 1'b1;
    sticky_err = jsv_pkg::ST_OK;
  endfunction

  function automatic verdict_t predict_verdict(byte_item_t it);
    verdict_t v;
    jsv_pkg::status_e code;
    if (it.func == F_TEXT) begin
      if (sticky_err == jsv_pkg::ST_OK) sticky_err = lex_byte(it.text_byte);
      v.status = sticky_err;
      v.done_res = 1'b0;
      v.nest_depth = 7'(depth);
    end else begin
      code = sticky_err;
      if (code == jsv_pkg::ST_OK) code = finish_token();
      if (code == jsv_pkg::ST_OK)
        code = (depth != 0 || gram == G_VALUE) ? jsv_pkg::ST_BADEND : jsv_pkg::ST_VALID;
      v.status = code;
      v.done_res = 1'b1;
      v.nest_depth = 7'(depth);
      clear_predictor();
    end
    return v;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back('{F_TEXT, s[i]});
  endtask

  task automatic push_doc(string s);
    push_text(s);
    pending_bytes.push_back('{F_END, 8'($urandom_range(0, 255))});
  endtask

  function automatic string rand_scalar();
    case ($urandom_range(0, 9))
      0: return "true";
      1: return "false";
      2: return "null";
      3: return $sformatf("%0d", $urandom_range(0, 99999));
      4: return $sformatf("-%0d.%0de%0d", $urandom_range(0, 99), $urandom_range(0, 9),
                          $urandom_range(0, 30));
      5: return "1.5E+3";
      6: return "\"a\\u0fA9\\n\"";
      7: return "\"\"";
      8: return "\"x\\\"y\"";
      default: return $sformatf("\"s%0d\"", $urandom_range(0, 999));
    endcase
  endfunction

  function automatic string ws();
    case ($urandom_range(0, 5))
      0: return " ";
      1: return "\n";
      2: return "\t ";
      default: return "";
    endcase
  endfunction

  function automatic string rand_value(int lvl);
    string s;
    int n;
    if (lvl > 3 || $urandom_range(0, 2) == 0) return rand_scalar();
    n = $urandom_range(0, 3);
    if ($urandom_range(0, 1)) begin
      s = "[";
      for (int i = 0; i < n; i++)
        s = {s, (i ? "," : ""), ws(), rand_value(lvl + 1)};
      if ($urandom_range(0, 9) == 0) s = {s, ","};
      return {s, "]"};
    end
    s = "{";
    for (int i = 0; i < n; i++)
      s = {s, (i ? "," : ""), $sformatf("\"k%0d\"", i), ws(), ":", rand_value(lvl + 1)};
    return {s, ws(), "}"};
  endfunction

  // damage a well-formed document in a random place
  function automatic string break_doc(string s);
    int p;
    logic [7:0] chars [8];
    chars = '{"}", "]", ",", ":", "\\", 8'hC3, "x", 8'h01};
    if (s.len() == 0) return s;
    p = $urandom_range(0, s.len() - 1);
    if ($urandom_range(0, 2) == 0) s[p] = 8'($urandom_range(0, 255));
    else s[p] = chars[$urandom_range(0, 7)];
    return s;
  endfunction

  task automatic fill_directed();
    string deep;
    push_doc("{\"a\":[1,-2.5e+3,true,false,null]}");
    push_doc("[1,]");
    push_doc("");
    push_doc("{\"\":1}");
    push_doc("\"\\u00Zz\"");
    push_doc("\"\\q\"");
    push_doc("1. -.5 ");
    push_doc("-.5");
    push_doc("01e");
    push_doc("tru");
    push_doc("[\"abc");
    push_doc("{}{}");
    push_doc("1 2");
    push_doc("{\"k\":1");
    push_doc({"\"", 8'hFF, 8'h00, 8'h80, "\"", " ", 8'hFF});
    push_doc(" \t\n\v\f\r null");
    deep = "";
    for (int i = 0; i < jsv_pkg::MaxDepth; i++) deep = {deep, "["};
    for (int i = 0; i < jsv_pkg::MaxDepth; i++) deep = {deep, "]"};
    push_doc(deep);
    push_doc({deep, "["});
  endtask

  task automatic fill_random(int target);
    string s;
    while (pending_bytes.size() < target) begin
      s = rand_value(0);
      case ($urandom_range(0, 9))
        0: s = break_doc(s);
        1: begin
          s = "";
          repeat ($urandom_range(1, 12)) s = {s, 8'($urandom_range(0, 255))};
        end
        default: ;
      endcase
      push_doc({ws(), s, ws()});
    end
  endtask

  // ---------------------------------------------------------------- driver

  function automatic bit sender_idles();
    case (phase)
      0: return $urandom_range(0, 99) < 19;
      1: return $urandom_range(0, 99) < 56;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (phase)
      0: return $urandom_range(0, 99) < 56;
      1: return $urandom_range(0, 99) < 19;
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      // transfer of current byte at this edge
      if (in_valid_i && !in_stall_o) begin
        expected_verdicts.push_back(predict_verdict('{func_i, text_byte_i}));
        void'(pending_bytes.pop_front());
      end
      // hold payload while stalled, otherwise offer the next byte
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_bytes.size() > (in_valid_i && !in_stall_o ? 0 : 0) &&
            !sender_idles()) begin
          in_valid_i  <= 1'b1;
          func_i      <= pending_bytes[0].func;
          text_byte_i <= pending_bytes[0].text_byte;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= receiver_stalls();
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result, status", status_o, -1);
      end else begin
        want = expected_verdicts.pop_front();
        if (status_o != want.status) report_mismatch("status", status_o, want.status);
        if (done_res_o != want.done_res) report_mismatch("done_res", done_res_o, want.done_res);
        if (nest_depth_o != want.nest_depth)
          report_mismatch("nest_depth", nest_depth_o, want.nest_depth);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_predictor();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    fill_directed();
    fill_random(600);
    // each idling profile drains before the next starts
    for (int p = 0; p < 3; p++) begin
      phase = p;
      if (p > 0) fill_random(570);
      while (pending_bytes.size() != 0 || expected_verdicts.size() != 0 || in_valid_i)
        @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
